FILE: src/lzw_pkg.sv
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared types and constants for the LZW compressor core.
// ----------------------------------------------------------------------------
package lzw_pkg;

	localparam int unsigned CODE_W     = 12;
	localparam int unsigned SYM_W      = 8;
	localparam int unsigned FIRST_FREE = 256;
	localparam int unsigned TDATA_IN_W = 8;
	localparam int unsigned TDATA_OUT_W = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_PUSH_MISS,
		ST_PUSH_LAST
	} ctrl_state_t;

	typedef struct packed {
		logic              end_flag;
		logic [CODE_W-1:0] code;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} push_req_t;

endpackage

FILE: src/lzw_dict.sv
// ----------------------------------------------------------------------------
// lzw_dict
// Dictionary store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lzw_dict #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12,
	parameter int unsigned KW    = 20
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [KW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [KW-1:0] rd_data
);

	logic [KW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/lzw_ctrl.sv
// ----------------------------------------------------------------------------
// lzw_ctrl
// Sequencer: prefix state, linear dictionary search with one comparator,
// entry insertion and result requests.
// ----------------------------------------------------------------------------
module lzw_ctrl #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12,
	parameter int unsigned KW    = 20,
	parameter int unsigned CNT_W = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lzw_pkg::SYM_W-1:0]    in_sym,
	input  logic                         in_last,
	output logic                         dict_wr_en,
	output logic [AW-1:0]                dict_wr_addr,
	output logic [KW-1:0]                dict_wr_data,
	output logic                         dict_rd_en,
	output logic [AW-1:0]                dict_rd_addr,
	input  logic [KW-1:0]                dict_rd_data,
	output lzw_pkg::push_req_t           push,
	input  logic                         push_ready
);

	localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(lzw_pkg::FIRST_FREE);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

	lzw_pkg::ctrl_state_t state_q, state_d;

	logic [AW-1:0]    prefix_q;
	logic             have_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic             last_q;
	logic [lzw_pkg::SYM_W-1:0] sym_q;
	logic [KW-1:0]    key_q;
	logic [AW-1:0]    emit_q;
	logic             rvalid_s1;
	logic [AW-1:0]    raddr_s1;

	logic             accept;
	logic             match;
	logic             hit;
	logic             miss;
	logic             clear;
	logic [AW-1:0]    sym_ext;
	logic [AW-1:0]    push_src;
	logic [AW+lzw_pkg::CODE_W-1:0] push_wide;

	assign sym_ext      = {{(AW-lzw_pkg::SYM_W){1'b0}}, in_sym};
	assign match        = rvalid_s1 && (dict_rd_data == key_q);
	assign dict_rd_addr = idx_q[AW-1:0];
	assign dict_wr_addr = count_q[AW-1:0];
	assign dict_wr_data = key_q;
	assign push_wide    = {{lzw_pkg::CODE_W{1'b0}}, push_src};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		accept          = 1'b0;
		hit             = 1'b0;
		miss            = 1'b0;
		clear           = 1'b0;
		dict_rd_en      = 1'b0;
		dict_wr_en      = 1'b0;
		push_src        = emit_q;
		push.valid      = 1'b0;
		push.item.end_flag = 1'b0;
		case (state_q)
			lzw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept = 1'b1;
					if (have_q) begin
						state_d = lzw_pkg::ST_SEARCH;
					end else if (in_last) begin
						state_d = lzw_pkg::ST_PUSH_LAST;
					end
				end
			end
			lzw_pkg::ST_SEARCH: begin
				if (match) begin
					hit     = 1'b1;
					state_d = last_q ? lzw_pkg::ST_PUSH_LAST : lzw_pkg::ST_IDLE;
				end else if (idx_q < count_q) begin
					dict_rd_en = 1'b1;
				end else begin
					miss       = 1'b1;
					dict_wr_en = (count_q < CNT_FULL);
					state_d    = lzw_pkg::ST_PUSH_MISS;
				end
			end
			lzw_pkg::ST_PUSH_MISS: begin
				push.valid = 1'b1;
				if (push_ready) begin
					state_d = last_q ? lzw_pkg::ST_PUSH_LAST : lzw_pkg::ST_IDLE;
				end
			end
			lzw_pkg::ST_PUSH_LAST: begin
				push.valid         = 1'b1;
				push.item.end_flag = 1'b1;
				push_src           = prefix_q;
				if (push_ready) begin
					clear   = 1'b1;
					state_d = lzw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lzw_pkg::ST_IDLE;
			end
		endcase
		push.item.code = push_wide[lzw_pkg::CODE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q    <= 1'b0;
			prefix_q  <= '0;
			count_q   <= CNT_FIRST;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= dict_rd_en;
			if (accept && !have_q) begin
				prefix_q <= sym_ext;
				have_q   <= 1'b1;
			end
			if (hit) begin
				prefix_q <= raddr_s1;
			end
			if (miss) begin
				prefix_q <= {{(AW-lzw_pkg::SYM_W){1'b0}}, sym_q};
			end
			if (dict_wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (clear) begin
				have_q   <= 1'b0;
				prefix_q <= '0;
				count_q  <= CNT_FIRST;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= in_sym;
			last_q <= in_last;
			key_q  <= {prefix_q, in_sym};
			idx_q  <= CNT_FIRST;
		end else if (dict_rd_en) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (dict_rd_en) begin
			raddr_s1 <= idx_q[AW-1:0];
		end
		if (miss) begin
			emit_q <= prefix_q;
		end
	end

endmodule

FILE: src/lzw_outq.sv
// ----------------------------------------------------------------------------
// lzw_outq
// Two-entry result queue between the sequencer and the output stream.
// ----------------------------------------------------------------------------
module lzw_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  lzw_pkg::push_req_t  push,
	output logic                push_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output lzw_pkg::out_item_t  out_item
);

	lzw_pkg::out_item_t entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign out_valid  = (fill_q != 2'd0);
	assign out_item   = entries_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: src/lzw_compressor_core.sv
// ----------------------------------------------------------------------------
// lzw_compressor_core
// LZW compressor, 12-bit codes, dictionary searched one entry per cycle.
// ----------------------------------------------------------------------------
// A later byte of a message is searched against the entries from 256 up to the fill
// count N until a match, and each byte queues 0 to 2 codes; no new byte is taken meanwhile.
// Throughput is bounded by the single read port and comparator; a full dictionary has
// 4096 entries, and input also waits while the result queue is full.
// Reset clears the sequencer and result queue; the dictionary is not cleared,
// only entries below the fill count are ever read.
module lzw_compressor_core #(
	parameter int unsigned DICT_ENTRIES = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lzw_pkg::TDATA_IN_W-1:0]   s_tdata,  // [7:0] symbol
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lzw_pkg::TDATA_OUT_W-1:0]  m_tdata,  // [11:0] code, [15:12] zero
	output logic                             m_tlast
);

	localparam int unsigned AW    = $clog2(DICT_ENTRIES);
	localparam int unsigned KW    = AW + lzw_pkg::SYM_W;
	localparam int unsigned CNT_W = AW + 1;

	logic               dict_wr_en;
	logic [AW-1:0]      dict_wr_addr;
	logic [KW-1:0]      dict_wr_data;
	logic               dict_rd_en;
	logic [AW-1:0]      dict_rd_addr;
	logic [KW-1:0]      dict_rd_data;
	lzw_pkg::push_req_t push;
	logic               push_ready;
	lzw_pkg::out_item_t out_item;

	lzw_dict #(
		.DEPTH (DICT_ENTRIES),
		.AW    (AW),
		.KW    (KW)
	) u_dict (
		.clk     (clk),
		.wr_en   (dict_wr_en),
		.wr_addr (dict_wr_addr),
		.wr_data (dict_wr_data),
		.rd_en   (dict_rd_en),
		.rd_addr (dict_rd_addr),
		.rd_data (dict_rd_data)
	);

	lzw_ctrl #(
		.DEPTH (DICT_ENTRIES),
		.AW    (AW),
		.KW    (KW),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_sym       (s_tdata[lzw_pkg::SYM_W-1:0]),
		.in_last      (s_tlast),
		.dict_wr_en   (dict_wr_en),
		.dict_wr_addr (dict_wr_addr),
		.dict_wr_data (dict_wr_data),
		.dict_rd_en   (dict_rd_en),
		.dict_rd_addr (dict_rd_addr),
		.dict_rd_data (dict_rd_data),
		.push         (push),
		.push_ready   (push_ready)
	);

	lzw_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_item   (out_item)
	);

	assign m_tdata = {{(lzw_pkg::TDATA_OUT_W - lzw_pkg::CODE_W){1'b0}}, out_item.code};
	assign m_tlast = out_item.end_flag;

endmodule

FILE: src/lzw_chk.sv
// ----------------------------------------------------------------------------
// lzw_chk
// Port-level checks for the LZW compressor core, bound to the top level.
// ----------------------------------------------------------------------------
module lzw_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output request changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:12] == 4'd0)
		else $error("code padding bits not zero");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken before final code was queued");

	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !$isunknown({s_tdata, s_tlast}))
		else $error("unknown bits on accepted input request");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown({m_tdata, m_tlast}))
		else $error("unknown bits on output request");

endmodule

bind lzw_compressor_core lzw_chk u_lzw_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
